/* rtl/cri_pkg.sv */
// Shared types and constants for the Catmull-Rom bicubic interpolator.
// No dependencies; imported by every module of the block.
package cri_pkg;

    localparam int CHANNELS = 4;
    localparam int SLOTS = 4;

    typedef logic signed [17:0] weight_t;
    typedef weight_t [3:0] weight_vec_t;
    typedef logic signed [39:0] col_sum_t;
    typedef logic signed [61:0] hacc_t;
    typedef hacc_t [SLOTS-1:0] hacc_vec_t;
    typedef logic [15:0] sample_t;
    typedef sample_t [3:0] sample_row_t;

    typedef struct packed {
        logic [15:0] gain;
        logic [15:0] frac_y;
        logic [15:0] frac_x;
        logic [1:0]  row_index;
        logic [63:0] pixel_col3;
        logic [63:0] pixel_col2;
        logic [63:0] pixel_col1;
        logic [63:0] pixel_col0;
    } in_item_t;

    typedef struct packed {
        logic [15:0] channel_3;
        logic [15:0] channel_2;
        logic [15:0] channel_1;
        logic [15:0] channel_0;
    } out_item_t;

    typedef struct packed {
        logic       vert_en;
        logic       vert_clear;
        logic       horiz_en;
        logic [1:0] col;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_ROW,
        ST_H,
        ST_GAIN,
        ST_FIN
    } state_t;

endpackage

/* rtl/cri_weight.sv */
// Three-stage pipeline that turns a Q0.16 fraction into four Q2.16 weights.
// Depends on cri_pkg.
module cri_weight
    import cri_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] frac,
    output weight_vec_t weights
);

    logic [15:0] f1_reg;
    logic [31:0] f2_reg;
    logic [15:0] f1b_reg;
    logic [31:0] f2b_reg;
    logic [47:0] f3_reg;
    logic signed [51:0] fs;
    logic signed [51:0] f2s;
    logic signed [51:0] f3s;
    logic signed [51:0] n0;
    logic signed [51:0] n2;
    logic signed [51:0] n3;
    logic signed [18:0] w0;
    logic signed [18:0] w2;
    logic signed [18:0] w3;
    logic signed [18:0] w1;
    localparam logic signed [51:0] HALF = 52'sd1 <<< 32;
    localparam logic signed [18:0] ONE = 19'sd65536;

    always_ff @(posedge clk)
    begin
        f1_reg  <= frac;
        f2_reg  <= 32'(frac * frac);
        f1b_reg <= f1_reg;
        f2b_reg <= f2_reg;
        f3_reg  <= 48'(f2_reg * f1_reg);
    end

    always_comb
    begin
        fs  = $signed({36'b0, f1b_reg});
        f2s = $signed({20'b0, f2b_reg});
        f3s = $signed({4'b0, f3_reg});
        n0  = -f3s + (f2s <<< 17) - (fs <<< 32) + HALF;
        n2  = -(f3s + (f3s <<< 1)) + (f2s <<< 18) + (fs <<< 32) + HALF;
        n3  = f3s - (f2s <<< 16) + HALF;
        w0  = n0[51:33];
        w2  = n2[51:33];
        w3  = n3[51:33];
        w1  = ONE - w0 - w2 - w3;
    end

    always_ff @(posedge clk)
    begin
        weights[0] <= w0[17:0];
        weights[1] <= w1[17:0];
        weights[2] <= w2[17:0];
        weights[3] <= w3[17:0];
    end

endmodule

/* rtl/cri_lane.sv */
// One channel lane: four column sums, vertical multiply-add, serial horizontal MAC.
// Depends on cri_pkg.
module cri_lane
    import cri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_ctrl_t  ctrl,
    input  sample_row_t samples,
    input  weight_t     wy,
    input  weight_t     wx,
    output hacc_t       acc
);

    col_sum_t sum_reg [4];
    hacc_t    acc_reg;
    logic signed [57:0] hprod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (ctrl.vert_en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c] <= (ctrl.vert_clear ? 40'sd0 : sum_reg[c])
                    + 40'($signed({1'b0, samples[c]}) * wy);
            end
        end
    end

    assign hprod = sum_reg[ctrl.col] * wx;

    always_ff @(posedge clk)
    begin
        if (ctrl.horiz_en)
        begin
            acc_reg <= (ctrl.col == 2'd0 ? 62'sd0 : acc_reg) + 62'(hprod);
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/cri_merge.sv */
// Merge stage: gain multiply, clamp and packing of the lane results.
// Depends on cri_pkg.
module cri_merge
    import cri_pkg::*;
(
    input  logic      clk,
    input  logic      load,
    input  hacc_vec_t accs,
    input  logic [15:0] gain,
    input  logic      mode16,
    output out_item_t result
);

    logic signed [61:0] p_reg [SLOTS];
    logic [15:0] ch [SLOTS];
    logic [33:0] q [SLOTS];
    logic [33:0] maxv;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                p_reg[i] <= 62'($signed(accs[i][61:16]) * $signed({1'b0, gain}));
            end
        end
    end

    always_comb
    begin
        maxv = mode16 ? 34'd65535 : 34'd255;
        for (int i = 0; i < SLOTS; i++)
        begin
            q[i] = p_reg[i][61:28];
            if (i >= CHANNELS || p_reg[i][61])
            begin
                ch[i] = 16'd0;
            end
            else if (q[i] > maxv)
            begin
                ch[i] = maxv[15:0];
            end
            else
            begin
                ch[i] = q[i][15:0];
            end
        end
        result.channel_0 = ch[0];
        result.channel_1 = ch[1];
        result.channel_2 = ch[2];
        result.channel_3 = ch[3];
    end

endmodule

/* rtl/catmull_rom_bicubic_interpolator_unit.sv */
// Top level of the Catmull-Rom bicubic interpolator: control, lanes and merge.
// Depends on cri_pkg, cri_weight, cri_lane and cri_merge.
//
// Usage: a 4x4 neighbourhood of four-channel pixels arrives one row per item
// on the in channel (valid/ready). Row 0 latches frac_x, frac_y and gain and
// restarts the column sums; rows 1..3 add to them. The item carrying row 3
// produces one result item on the out channel (valid/ready).
// cfg carries the one mode bit (1 = 16-bit samples); it is always ready.
// Timing: each row is accepted, passes the weight pipeline (W1, W2, W3) and
// gets one lane multiply-add (ROW). Row 3 then runs the weight pipeline again
// for the horizontal weights, the serial column MAC per lane (H) and the gain
// step (GAIN); the result registers in FIN once the output register is free.
// The weight pipeline and the serial horizontal MAC set this timing.
// A result waits in the output register while the next rows are worked on;
// if the receiver still stalls when the next result is due, the block holds.
// Reset clears the column sums, held fractions, gain, mode and all control.
module catmull_rom_bicubic_interpolator_unit
    import cri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    state_t state_reg, state_next;
    logic [1:0] col_reg, col_next;
    logic phase_x_reg, phase_x_next;
    logic mode_reg;
    logic [15:0] frac_x_reg, frac_y_reg, gain_reg;
    in_item_t item_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic accept;
    logic fin_go;
    logic merge_load;
    lane_ctrl_t ctrl;
    weight_vec_t weights;
    hacc_vec_t accs;
    out_item_t merged;
    logic [63:0] cols [4];

    assign accept = in_valid && in_ready;
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        col_next = col_reg;
        phase_x_next = phase_x_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_W1;
                    phase_x_next = 1'b0;
                end
            end
            ST_W1: state_next = ST_W2;
            ST_W2: state_next = ST_W3;
            ST_W3:
            begin
                state_next = phase_x_reg ? ST_H : ST_ROW;
                col_next = 2'd0;
            end
            ST_ROW:
            begin
                if (item_reg.row_index == 2'd3)
                begin
                    state_next = ST_W1;
                    phase_x_next = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_H:
            begin
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd3)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        ctrl.vert_en = (state_reg == ST_ROW);
        ctrl.vert_clear = (item_reg.row_index == 2'd0);
        ctrl.horiz_en = (state_reg == ST_H);
        ctrl.col = col_reg;
        merge_load = (state_reg == ST_GAIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg <= 2'd0;
            phase_x_reg <= 1'b0;
            mode_reg <= 1'b0;
            frac_x_reg <= '0;
            frac_y_reg <= '0;
            gain_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            phase_x_reg <= phase_x_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (accept && in_data.row_index == 2'd0)
            begin
                frac_x_reg <= in_data.frac_x;
                frac_y_reg <= in_data.frac_y;
                gain_reg <= in_data.gain;
            end
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (fin_go)
        begin
            out_reg <= merged;
        end
    end

    cri_weight u_weight (
        .clk     (clk),
        .frac    (phase_x_reg ? frac_x_reg : frac_y_reg),
        .weights (weights)
    );

    assign cols[0] = item_reg.pixel_col0;
    assign cols[1] = item_reg.pixel_col1;
    assign cols[2] = item_reg.pixel_col2;
    assign cols[3] = item_reg.pixel_col3;

    for (genvar ch = 0; ch < SLOTS; ch++)
    begin : g_lane
        if (ch < CHANNELS)
        begin : g_on
            sample_row_t samples;
            always_comb
            begin
                for (int c = 0; c < 4; c++)
                begin
                    samples[c] = mode_reg ? cols[c][16*ch +: 16]
                                          : {8'd0, cols[c][16*ch +: 8]};
                end
            end
            cri_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .samples (samples),
                .wy      (weights[item_reg.row_index]),
                .wx      (weights[col_reg]),
                .acc     (accs[ch])
            );
        end
        else
        begin : g_off
            assign accs[ch] = '0;
        end
    end

    cri_merge u_merge (
        .clk    (clk),
        .load   (merge_load),
        .accs   (accs),
        .gain   (gain_reg),
        .mode16 (mode_reg),
        .result (merged)
    );

endmodule

/* dv/tb.sv */
// Testbench for catmull_rom_bicubic_interpolator_unit: drives neighbourhood rows,
// predicts every interpolated pixel in the bench and compares the results in order.
// Depends on cri_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
    import cri_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    catmull_rom_bicubic_interpolator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    localparam longint CYCLE_LIMIT = 600000;

    in_item_t  pending_rows[$];
    out_item_t expected_pixels[$];
    logic      mode16;
    logic signed [39:0] col_acc[16];
    logic [15:0] hold_fx, hold_fy, hold_gain;
    int        errors = 0;
    longint    cycle_count = 0;
    bit        stall_out = 1'b0;
    int        out_gap = 0;
    int        in_gap = 0;

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic void cr_weights(input logic [15:0] fr, output longint w[4]);
        longint f, f2, f3, t;
        f = fr; t = 65536; f2 = f * f; f3 = f2 * f;
        w[0] = fshift(-f3 + 2 * f2 * t - f * t * t + (64'sd1 <<< 32), 33);
        w[2] = fshift(-3 * f3 + 4 * f2 * t + f * t * t + (64'sd1 <<< 32), 33);
        w[3] = fshift(f3 - f2 * t + (64'sd1 <<< 32), 33);
        w[1] = 65536 - w[0] - w[2] - w[3];
    endfunction

    function automatic void interp_row(in_item_t it);
        longint wy[4], wx[4], s, acc, h, p, q, maxv;
        logic [63:0] px;
        logic [15:0] res[4];
        out_item_t o;
        maxv = mode16 ? 65535 : 255;
        if (it.row_index == 2'd0) begin
            hold_fx = it.frac_x; hold_fy = it.frac_y; hold_gain = it.gain;
        end
        cr_weights(hold_fy, wy);
        for (int c = 0; c < 4; c++) begin
            px = (c == 0) ? it.pixel_col0 : (c == 1) ? it.pixel_col1 :
                 (c == 2) ? it.pixel_col2 : it.pixel_col3;
            for (int ch = 0; ch < 4; ch++) begin
                s = mode16 ? px[16*ch +: 16] : px[16*ch +: 8];
                if (it.row_index == 2'd0)
                    col_acc[c*4+ch] = 40'(s * wy[it.row_index]);
                else
                    col_acc[c*4+ch] = col_acc[c*4+ch] + 40'(s * wy[it.row_index]);
            end
        end
        if (it.row_index != 2'd3) return;
        cr_weights(hold_fx, wx);
        for (int ch = 0; ch < 4; ch++) begin
            acc = 0;
            res[ch] = '0;
            if (ch < CHANNELS) begin
                for (int c = 0; c < 4; c++) acc += longint'(col_acc[c*4+ch]) * wx[c];
                h = fshift(acc, 16);
                p = h * longint'(hold_gain);
                if (p >= 0) begin
                    q = fshift(p, 28);
                    res[ch] = 16'(q > maxv ? maxv : q);
                end
            end
        end
        o.channel_0 = res[0]; o.channel_1 = res[1];
        o.channel_2 = res[2]; o.channel_3 = res[3];
        expected_pixels.push_back(o);
    endfunction

    function automatic logic [63:0] rand_pixel(int kind);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (kind)
            0: v = '0;
            1: v = '1;
            2: for (int ch = 0; ch < 4; ch++) v[16*ch +: 16] = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0;
            default: ;
        endcase
        return v;
    endfunction

    function automatic in_item_t make_row(logic [1:0] r, int kind, logic [15:0] fx,
                                          logic [15:0] fy, logic [15:0] g);
        in_item_t it;
        it.pixel_col0 = rand_pixel(kind); it.pixel_col1 = rand_pixel(kind);
        it.pixel_col2 = rand_pixel(kind); it.pixel_col3 = rand_pixel(kind);
        it.row_index = r; it.frac_x = fx; it.frac_y = fy; it.gain = g;
        return it;
    endfunction

    task automatic queue_set(int kind, logic [15:0] fx, logic [15:0] fy, logic [15:0] g);
        for (int r = 0; r < 4; r++)
            pending_rows.push_back(make_row(2'(r), kind, fx, fy, g));
    endtask

    task automatic wait_drain();
        while (pending_rows.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        mode16 = m;
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge clk) begin
        if (in_valid && in_ready) interp_row(in_data);
        if (!in_valid || in_ready) begin
            if (rst_n && in_gap == 0 && pending_rows.size() != 0) begin
                in_data <= pending_rows.pop_front();
                in_valid <= 1'b1;
                in_gap <= ($urandom_range(0, 9) == 0) ?
                          (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
            end else begin
                in_valid <= 1'b0;
                if (rst_n && in_gap > 0) in_gap <= in_gap - 1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end else begin
                out_item_t e;
                e = expected_pixels.pop_front();
                if (e.channel_0 !== out_data.channel_0 || e.channel_1 !== out_data.channel_1 ||
                    e.channel_2 !== out_data.channel_2 || e.channel_3 !== out_data.channel_3) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
                    errors++;
                end
            end
        end
        if (stall_out) out_ready <= 1'b0;
        else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                out_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        mode16 = 1'b0;
        hold_fx = '0; hold_fy = '0; hold_gain = '0;
        for (int i = 0; i < 16; i++) col_acc[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, 8-bit mode from reset
        queue_set(1, 16'h0, 16'h0, 16'h1000);
        queue_set(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_set(0, 16'h8000, 16'h8000, 16'hFFFF);
        pending_rows.push_back(make_row(2'd3, 3, 16'h1234, 16'h4321, 16'h2000));
        pending_rows.push_back(make_row(2'd0, 2, 16'h4000, 16'hC000, 16'h1800));
        pending_rows.push_back(make_row(2'd2, 2, 16'h0, 16'h0, 16'h0));
        pending_rows.push_back(make_row(2'd1, 2, 16'h0, 16'h0, 16'h0));
        pending_rows.push_back(make_row(2'd1, 2, 16'h0, 16'h0, 16'h0));
        pending_rows.push_back(make_row(2'd3, 2, 16'h0, 16'h0, 16'h0));
        wait_drain();
        write_mode(1'b1);
        queue_set(1, 16'h8000, 16'h2000, 16'hFFFF);
        queue_set(2, 16'hFFFF, 16'h0001, 16'h1000);

        // long receiver hold-off while rows keep coming
        stall_out = 1'b1;
        for (int i = 0; i < 6; i++) queue_set(3, rand_field(), rand_field(), rand_field());
        repeat (400) @(posedge clk);
        stall_out = 1'b0;
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_mode((ph % 2) == 0);
            for (int s = 0; s < 50; s++) begin
                if ($urandom_range(0, 9) == 0) begin
                    int n;
                    n = $urandom_range(1, 5);
                    for (int k = 0; k < n; k++)
                        pending_rows.push_back(make_row(2'($urandom_range(0, 3)),
                            $urandom_range(0, 4), rand_field(), rand_field(), rand_field()));
                end else begin
                    queue_set($urandom_range(0, 6), rand_field(), rand_field(), rand_field());
                end
            end
            wait_drain();
        end

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
